>>> rtl/slid_pkg.sv
// ============================================================================
// slid_pkg - shared types for the sorted list block
// Field widths, action and status codes, cell control and sequencer types.
// ============================================================================
package slid_pkg;

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 16;
    localparam int TAG_W    = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY_POS = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        logic [TAG_W-1:0]    tag;
        logic [POS_W-1:0]    position;
    } slid_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    out_key;
        logic [TAG_W-1:0]    out_tag;
        logic [COUNT_W-1:0]  entry_count;
    } slid_rsp_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_LEFT,
        OP_RIGHT
    } slid_cell_op_t;

    typedef struct packed {
        logic          flag_en;
        slid_cell_op_t op;
    } slid_cell_ctrl_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } slid_cell_flag_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } slid_state_t;

endpackage

>>> rtl/slid_req_if.sv
// ============================================================================
// slid_req_if - request channel
// Valid/ready channel carrying one action beat.
// ============================================================================
interface slid_req_if;
    import slid_pkg::*;

    logic      valid;
    logic      ready;
    slid_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/slid_rsp_if.sv
// ============================================================================
// slid_rsp_if - response channel
// Valid/ready channel carrying one result beat.
// ============================================================================
interface slid_rsp_if;
    import slid_pkg::*;

    logic      valid;
    logic      ready;
    slid_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/slid_cell.sv
// ============================================================================
// slid_cell - one list slot
// Holds one key and tag, compares against the operand key and loads from
// the new entry or a neighbor on command.
// ============================================================================
module slid_cell #(
    parameter int KW = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  slid_pkg::slid_cell_ctrl_t ctrl,
    input  logic                      is_valid,
    input  logic [KW-1:0]             cmp_key,
    input  logic [slid_pkg::TAG_W-1:0] new_tag,
    input  logic [KW-1:0]             left_key,
    input  logic [slid_pkg::TAG_W-1:0] left_tag,
    input  logic [KW-1:0]             right_key,
    input  logic [slid_pkg::TAG_W-1:0] right_tag,
    output logic [KW-1:0]             key_q,
    output logic [slid_pkg::TAG_W-1:0] tag_q,
    output slid_pkg::slid_cell_flag_t flags
);
    import slid_pkg::*;

    logic [KW-1:0]    key_reg;
    logic [TAG_W-1:0] tag_reg;
    slid_cell_flag_t  flag_reg;
    slid_cell_flag_t  flag_next;

    always_comb
    begin
        flag_next.lt = is_valid && (key_reg < cmp_key);
        flag_next.eq = is_valid && (key_reg == cmp_key);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= '0;
        end
        else if (ctrl.flag_en)
        begin
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_HOLD:
            begin
                key_reg <= key_reg;
                tag_reg <= tag_reg;
            end
            OP_LOAD:
            begin
                key_reg <= cmp_key;
                tag_reg <= new_tag;
            end
            OP_LEFT:
            begin
                key_reg <= left_key;
                tag_reg <= left_tag;
            end
            OP_RIGHT:
            begin
                key_reg <= right_key;
                tag_reg <= right_tag;
            end
            default:
            begin
                key_reg <= key_reg;
                tag_reg <= tag_reg;
            end
        endcase
    end

    assign key_q = key_reg;
    assign tag_q = tag_reg;
    assign flags = flag_reg;

endmodule

>>> rtl/sorted_list_insert_delete.sv
// ============================================================================
// sorted_list_insert_delete - sorted key/tag list in a row of cells
// Insert in key order, delete first matching key, read by position.
// ============================================================================
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  --------------------------------------
//  req      in   req.valid/ready    action, key, tag, position
//  rsp      out  rsp.valid/ready    status, out_key, out_tag, entry_count
//
//  Each beat goes through accept, compare in every cell (flags are
//  registered), then shift the row and load the result register.
//  One beat is in flight at a time; the next is taken in the cycle after the
//  row shifts, even while the previous result still waits on rsp.
//  A stalled rsp holds the shift step until the result register frees.
//  Reset clears the entry count and the handshake state; no clearing pass.
//
module sorted_list_insert_delete #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    slid_req_if.sink    req,
    slid_rsp_if.source  rsp
);
    import slid_pkg::*;

    localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SEL_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    slid_state_t state_reg;
    slid_state_t state_next;

    logic [ACTION_W-1:0] act_reg;
    logic [KW-1:0]       opkey_reg;
    logic [TAG_W-1:0]    optag_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;

    logic      rsp_valid_reg;
    slid_rsp_t rsp_data_reg;
    slid_rsp_t rsp_data_next;

    logic req_ready;
    logic flag_en;
    logic apply_en;

    logic [KW-1:0]    cell_key [CAPACITY];
    logic [TAG_W-1:0] cell_tag [CAPACITY];
    slid_cell_flag_t  cell_flag [CAPACITY];
    slid_cell_ctrl_t  cell_ctrl [CAPACITY];
    logic             cell_valid [CAPACITY];

    logic             found;
    logic             read_ok;
    logic [KW-1:0]    read_key;
    logic [TAG_W-1:0] read_tag;
    logic             is_full;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        flag_en   = 1'b0;
        apply_en  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_CMP:
            begin
                flag_en = 1'b1;
            end
            ST_APPLY:
            begin
                apply_en = !rsp_valid_reg || rsp.ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Latch the operand beat
    always_ff @(posedge clk)
    begin
        if (req.valid && req_ready)
        begin
            act_reg   <= req.data.action;
            opkey_reg <= req.data.key[KW-1:0];
            optag_reg <= req.data.tag;
            pos_reg   <= req.data.position;
        end
    end

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    assign is_full = (cnt_reg == FULL_CNT);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        logic [KW-1:0]    lkey;
        logic [TAG_W-1:0] ltag;
        logic [KW-1:0]    rkey;
        logic [TAG_W-1:0] rtag;

        assign cell_valid[i] = (IDX < cnt_reg);

        if (i == 0)
        begin : g_first
            assign lkey = cell_key[i];
            assign ltag = cell_tag[i];
        end
        else
        begin : g_mid
            assign lkey = cell_key[i-1];
            assign ltag = cell_tag[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rkey = cell_key[i];
            assign rtag = cell_tag[i];
        end
        else
        begin : g_inner
            assign rkey = cell_key[i+1];
            assign rtag = cell_tag[i+1];
        end

        slid_cell #(
            .KW(KW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl[i]),
            .is_valid  (cell_valid[i]),
            .cmp_key   (opkey_reg),
            .new_tag   (optag_reg),
            .left_key  (lkey),
            .left_tag  (ltag),
            .right_key (rkey),
            .right_tag (rtag),
            .key_q     (cell_key[i]),
            .tag_q     (cell_tag[i]),
            .flags     (cell_flag[i])
        );
    end

    // Any stored match means the first key >= operand equals it
    always_comb
    begin
        found = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found = found | cell_flag[i].eq;
        end
    end

    always_comb
    begin
        read_ok  = 1'b0;
        read_key = '0;
        read_tag = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if ((SEL_W'(i) == SEL_W'(pos_reg)) && cell_valid[i])
            begin
                read_ok  = 1'b1;
                read_key = read_key | cell_key[i];
                read_tag = read_tag | cell_tag[i];
            end
        end
    end

    // Per-cell shift commands: cells below the split hold, the rest move on a non-full insert or a found delete
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_ctrl[i].flag_en = flag_en;
            cell_ctrl[i].op      = OP_HOLD;
            if (apply_en && !cell_flag[i].lt)
            begin
                case (act_reg)
                    ACT_INSERT:
                    begin
                        if (!is_full)
                        begin
                            if (i == 0)
                            begin
                                cell_ctrl[i].op = OP_LOAD;
                            end
                            else if (cell_flag[(i == 0) ? 0 : i - 1].lt)
                            begin
                                cell_ctrl[i].op = OP_LOAD;
                            end
                            else
                            begin
                                cell_ctrl[i].op = OP_LEFT;
                            end
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (found)
                        begin
                            cell_ctrl[i].op = OP_RIGHT;
                        end
                    end
                    default:
                    begin
                        cell_ctrl[i].op = OP_HOLD;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Count and result
    // ------------------------------------------------------------------
    always_comb
    begin
        cnt_next      = cnt_reg;
        rsp_data_next = '0;
        case (act_reg)
            ACT_INSERT:
            begin
                if (is_full)
                begin
                    rsp_data_next.status = STAT_FULL;
                end
                else
                begin
                    cnt_next             = cnt_reg + 1'b1;
                    rsp_data_next.status = STAT_DONE;
                end
            end
            ACT_DELETE:
            begin
                if (found)
                begin
                    cnt_next             = cnt_reg - 1'b1;
                    rsp_data_next.status = STAT_DONE;
                end
                else
                begin
                    rsp_data_next.status = STAT_NOT_FOUND;
                end
            end
            ACT_READ:
            begin
                if (read_ok)
                begin
                    rsp_data_next.status  = STAT_DONE;
                    rsp_data_next.out_key = KEY_W'(read_key);
                    rsp_data_next.out_tag = read_tag;
                end
                else
                begin
                    rsp_data_next.status = STAT_EMPTY_POS;
                end
            end
            default:
            begin
                rsp_data_next.status = STAT_DONE;
            end
        endcase
        rsp_data_next.entry_count = COUNT_W'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (apply_en)
            begin
                cnt_reg       <= cnt_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply_en)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

>>> tb/sorted_list_insert_delete_checker.sv
// ============================================================================
// sorted_list_insert_delete_checker - result predictor and comparator
// Watches the request and response channels and keeps a shadow of the sorted
// list. Each accepted action produces one predicted result beat. Each result
// beat is compared field by field against the oldest prediction.
// ============================================================================
module sorted_list_insert_delete_checker #(
    parameter int CAPACITY = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    slid_req_if        req,
    slid_rsp_if        rsp,
    output int         fail_count,
    output int         outstanding,
    output int         full_refusals,
    output int         delete_hits,
    output int         peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;
    import slid_pkg::*;

    logic [KEY_W-1:0] key_row [CAPACITY];
    logic [TAG_W-1:0] tag_row [CAPACITY];
    int               fill;
    slid_rsp_t        due_q [$];
    slid_rsp_t        want;
    slid_rsp_t        got;

    // Apply one action to the shadow list and return the result it should give.
    function automatic slid_rsp_t apply_action(input slid_req_t r);
        slid_rsp_t res;
        int        at;
        res = '0;
        res.status = STAT_DONE;
        at = 0;
        case (r.action)
            ACT_INSERT:
            begin
                if (fill >= CAPACITY) begin
                    res.status = STAT_FULL;
                    full_refusals++;
                end
                else begin
                    // equal keys already stored stay behind the new one
                    while (at < fill && key_row[at] < r.key) at++;
                    for (int i = fill; i > at; i--) begin
                        key_row[i] = key_row[i-1];
                        tag_row[i] = tag_row[i-1];
                    end
                    key_row[at] = r.key;
                    tag_row[at] = r.tag;
                    fill++;
                end
            end
            ACT_DELETE:
            begin
                while (at < fill && key_row[at] < r.key) at++;
                if (at >= fill || key_row[at] != r.key) begin
                    res.status = STAT_NOT_FOUND;
                end
                else begin
                    for (int i = at; i + 1 < fill; i++) begin
                        key_row[i] = key_row[i+1];
                        tag_row[i] = tag_row[i+1];
                    end
                    fill--;
                    delete_hits++;
                end
            end
            ACT_READ:
            begin
                if (int'(r.position) < fill) begin
                    res.out_key = key_row[r.position];
                    res.out_tag = tag_row[r.position];
                end
                else begin
                    res.status = STAT_EMPTY_POS;
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = fill[COUNT_W-1:0];
        if (fill > peak_fill) peak_fill = fill;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill = 0;
            due_q.delete();
        end
        else begin
            if (req.valid && req.ready) due_q.push_back(apply_action(req.data));
            if (rsp.valid && rsp.ready) begin
                got = rsp.data;
                if (due_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat status=%0d key=%h tag=%h count=%0d",
                             $time, got.status, got.out_key, got.out_tag, got.entry_count);
                end
                else begin
                    want = due_q.pop_front();
                    if (got.status !== want.status) begin
                        fail_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.out_key !== want.out_key) begin
                        fail_count++;
                        $display("%0t: out_key expected %h actual %h",
                                 $time, want.out_key, got.out_key);
                    end
                    if (got.out_tag !== want.out_tag) begin
                        fail_count++;
                        $display("%0t: out_tag expected %h actual %h",
                                 $time, want.out_tag, got.out_tag);
                    end
                    if (got.entry_count !== want.entry_count) begin
                        fail_count++;
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, got.entry_count);
                    end
                end
            end
        end
        outstanding <= due_q.size();
    end

    initial
    begin
        fail_count    = 0;
        outstanding   = 0;
        full_refusals = 0;
        delete_hits   = 0;
        peak_fill     = 0;
    end

endmodule

>>> tb/sorted_list_insert_delete_tb.sv
// ============================================================================
// sorted_list_insert_delete_tb - top of the sorted list testbench
// Drives directed and random insert, delete, read and unused actions with
// random gaps and response stalls; the checker predicts and compares.
// ============================================================================
module sorted_list_insert_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import slid_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1900;
    localparam int POOL_DEPTH   = 32;

    logic clk;
    logic rst_n;
    bit   steady;
    int   sent;

    int   fail_count;
    int   outstanding;
    int   full_refusals;
    int   delete_hits;
    int   peak_fill;

    logic [KEY_W-1:0] recent [POOL_DEPTH];
    int               recent_n;

    slid_req_if req ();
    slid_rsp_if rsp ();

    sorted_list_insert_delete #(
        .CAPACITY (16),
        .KEY_BITS (16)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    sorted_list_insert_delete_checker #(
        .CAPACITY (16)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .full_refusals (full_refusals),
        .delete_hits   (delete_hits),
        .peak_fill     (peak_fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic slid_req_t make_req(input logic [ACTION_W-1:0] act,
                                           input logic [KEY_W-1:0] k,
                                           input logic [TAG_W-1:0] t,
                                           input logic [POS_W-1:0] p);
        slid_req_t r;
        r.action   = act;
        r.key      = k;
        r.tag      = t;
        r.position = p;
        return r;
    endfunction

    // Bias keys toward a small range and recent inserts so deletes hit.
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45) return KEY_W'($urandom_range(0, 23));
        if (roll < 75 && recent_n > 0)
            return recent[$urandom_range(0, (recent_n < POOL_DEPTH ? recent_n : POOL_DEPTH) - 1)];
        if (roll < 85) return ($urandom_range(1) != 0) ? '1 : '0;
        return KEY_W'($urandom());
    endfunction

    task automatic send(input slid_req_t item);
        int gap;
        if (!steady && $urandom_range(99) < 37) begin
            gap = $urandom_range(1, 4);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= item;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        if (item.action == ACT_INSERT) begin
            recent[recent_n % POOL_DEPTH] = item.key;
            recent_n++;
        end
        sent++;
    endtask

    // Response side stalls per cycle except during the steady stretch.
    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= steady || ($urandom_range(99) >= 37);
        end
    end

    initial
    begin
        #10_000_000;
        $display("sorted_list_insert_delete_tb: FAIL");
        $finish;
    end

    initial
    begin
        int                  mode;
        int                  roll;
        int                  ins_w;
        int                  del_w;
        logic [ACTION_W-1:0] act;

        steady    = 1'b0;
        sent      = 0;
        recent_n  = 0;
        rst_n     <= 1'b0;
        req.valid <= 1'b0;
        req.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // read and delete on an empty list
        send(make_req(ACT_READ,   16'h0000, 32'h0,        4'd0));
        send(make_req(ACT_READ,   16'h0000, 32'h0,        4'd15));
        send(make_req(ACT_DELETE, 16'h0005, 32'h0,        4'd0));
        // key and tag extremes
        send(make_req(ACT_INSERT, 16'h0000, 32'h0000_0000, 4'd0));
        send(make_req(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 4'd0));
        // equal key goes ahead of the stored one
        send(make_req(ACT_INSERT, 16'h0064, 32'h1111_AAAA, 4'd0));
        send(make_req(ACT_INSERT, 16'h0064, 32'h2222_BBBB, 4'd0));
        send(make_req(ACT_READ,   16'h0000, 32'h0,        4'd1));
        send(make_req(ACT_READ,   16'h0000, 32'h0,        4'd2));
        send(make_req(ACT_READ,   16'h0000, 32'h0,        4'd3));
        // remove the head entry
        send(make_req(ACT_DELETE, 16'h0000, 32'h0,        4'd0));
        send(make_req(ACT_READ,   16'h0000, 32'h0,        4'd0));
        // absent key below a larger one, and one just below the largest
        send(make_req(ACT_DELETE, 16'h0032, 32'h0,        4'd0));
        send(make_req(ACT_DELETE, 16'hFFFE, 32'h0,        4'd0));
        send(make_req(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 4'd15));
        send(make_req(ACT_READ,   16'h0000, 32'h0,        4'd3));
        send(make_req(ACT_READ,   16'h0000, 32'h0,        4'd15));
        send(make_req(ACT_DELETE, 16'hFFFF, 32'h0,        4'd0));
        send(make_req(ACT_DELETE, 16'h0064, 32'h0,        4'd0));
        send(make_req(ACT_READ,   16'h0000, 32'h0,        4'd0));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 700 && n < 1000);
            mode = (n / 120) % 3;
            case (mode)
                0:       begin ins_w = 60; del_w = 15; end
                1:       begin ins_w = 15; del_w = 60; end
                default: begin ins_w = 35; del_w = 30; end
            endcase
            roll = $urandom_range(99);
            if (roll < ins_w)              act = ACT_INSERT;
            else if (roll < ins_w + del_w) act = ACT_DELETE;
            else if (roll < 96)            act = ACT_READ;
            else                           act = ACT_UNUSED;
            send(make_req(act, pick_key(), $urandom(), POS_W'($urandom_range(0, 15))));
        end
        steady = 1'b0;
        req.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d actions with random gaps and stalls; peak fill %0d",
                 sent, peak_fill);
        $display("Inserts refused on a full list: %0d, deletes that found their key: %0d",
                 full_refusals, delete_hits);
        if (fail_count == 0 && outstanding == 0) begin
            $display("sorted_list_insert_delete_tb: PASS");
        end
        else begin
            $display("sorted_list_insert_delete_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/slid_pkg.sv
rtl/slid_req_if.sv
rtl/slid_rsp_if.sv
rtl/slid_cell.sv
rtl/sorted_list_insert_delete.sv
tb/sorted_list_insert_delete_checker.sv
tb/sorted_list_insert_delete_tb.sv
